>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the input event tracker. The
// checks compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// The property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// The condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

>>> sv/iest_pkg.sv
// ----------------------------------------------------------------------------
// Input event state tracker package
// Shared constants, message codes and the types passed between the front
// end, the request queue and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package iest_pkg;

   // Key table geometry.
   localparam int KEY_TABLE_DEPTH = 256;
   localparam int KEY_IDX_W       = $clog2(KEY_TABLE_DEPTH);

   // Keys whose state lives in dedicated registers.
   localparam logic [KEY_IDX_W-1:0] KEY_SHIFT   = KEY_IDX_W'(8'h10);
   localparam logic [KEY_IDX_W-1:0] KEY_CONTROL = KEY_IDX_W'(8'h11);
   localparam logic [KEY_IDX_W-1:0] KEY_ALT     = KEY_IDX_W'(8'h12);

   // Key state bits.
   localparam int KS_TOGGLE = 0;
   localparam int KS_DOWN   = 1;

   // Request queue geometry.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Configuration register indexes.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_INPUT_ENABLED   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BUTTONS_SWAPPED = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT   = 2'd3;

   // Raw mouse flag bits.
   localparam int MF_MOVE        = 0;
   localparam int MF_ABSOLUTE    = 1;
   localparam int MF_LEFT_DOWN   = 2;
   localparam int MF_LEFT_UP     = 3;
   localparam int MF_RIGHT_DOWN  = 4;
   localparam int MF_RIGHT_UP    = 5;
   localparam int MF_MIDDLE_DOWN = 6;
   localparam int MF_MIDDLE_UP   = 7;
   localparam int MF_WHEEL       = 8;

   // Decoded mouse message mask, in emission order.
   localparam int EV_MOVE        = 0;
   localparam int EV_LEFT_DOWN   = 1;
   localparam int EV_LEFT_UP     = 2;
   localparam int EV_RIGHT_DOWN  = 3;
   localparam int EV_RIGHT_UP    = 4;
   localparam int EV_MIDDLE_DOWN = 5;
   localparam int EV_MIDDLE_UP   = 6;
   localparam int EV_WHEEL       = 7;
   localparam int EV_MASK_W      = 8;
   localparam int EV_IDX_W       = $clog2(EV_MASK_W);

   // Driver key state bits, which are also the modifier word bits.
   localparam int DK_LEFT    = 0;
   localparam int DK_RIGHT   = 1;
   localparam int DK_SHIFT   = 2;
   localparam int DK_CONTROL = 3;
   localparam int DK_MIDDLE  = 4;
   localparam int DK_W       = 5;

   typedef enum logic [3:0] {
      MSG_KEYDOWN       = 4'd0,
      MSG_KEYUP         = 4'd1,
      MSG_SYSKEYDOWN    = 4'd2,
      MSG_SYSKEYUP      = 4'd3,
      MSG_MOVE          = 4'd4,
      MSG_LBUTTONDOWN   = 4'd5,
      MSG_LBUTTONUP     = 4'd6,
      MSG_RBUTTONDOWN   = 4'd7,
      MSG_RBUTTONUP     = 4'd8,
      MSG_MBUTTONDOWN   = 4'd9,
      MSG_MBUTTONUP     = 4'd10,
      MSG_WHEEL         = 4'd11
   } msg_kind_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_KEY,
      BK_EMIT
   } back_state_type;

   // Effective screen size, never zero.
   typedef struct packed {
      logic [15:0] width;
      logic [15:0] height;
   } screen_cfg_type;

   // One classified request as it waits in the queue.
   typedef struct packed {
      logic                 is_mouse;
      logic [KEY_IDX_W-1:0] virtual_key;
      logic [7:0]           scan_code;
      logic                 key_up;
      logic                 extended_key;
      logic                 force_extended;
      logic                 move;
      logic                 absolute;
      logic [16:0]          move_x;
      logic [16:0]          move_y;
      logic [EV_MASK_W-1:0] event_mask;
      logic                 driver_info_valid;
      logic [DK_W-1:0]      driver_key_state;
   } queue_entry_type;

endpackage

`default_nettype wire

>>> sv/input_event_state_tracker_core.sv
// ----------------------------------------------------------------------------
// Input event state tracker
// Turns raw keyboard and mouse requests into window messages.
// ----------------------------------------------------------------------------
// Usage:
// Requests enter on the req_ channel and are taken at a clock edge with
// req_valid high and req_stall low. A keyboard request gives one message; a
// mouse request gives zero to eight, the final one flagged by rsp_last.
// Messages leave on the rsp_ channel from a result register and are taken at
// an edge with rsp_valid high and rsp_stall low. While the receiver stalls,
// the message holds and the queue keeps taking requests until it fills.
// On an empty block a request passes the queue slot and the back end's item
// register before its first message is loaded into the result register. In
// the back end a keyboard request takes a registered read of the key table
// followed by its write back. A mouse request is applied as it is popped,
// then emits its messages in turn. Configuration is written through csr_
// while the block is idle; the user keeps to it, the block does not enforce
// it. Reset enables input, clears buttons, keys and cursor and restores a
// 1024 by 768 screen; the key table needs no clearing pass after reset.
// Requests taken while input is disabled are dropped without effect.
// ----------------------------------------------------------------------------
`default_nettype none

module input_event_state_tracker_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [1:0]           csr_index,
   input  logic [15:0]          csr_write_data,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_operation,
   input  logic [7:0]           req_virtual_key,
   input  logic [7:0]           req_scan_code,
   input  logic                 req_key_up,
   input  logic                 req_extended_key,
   input  logic                 req_force_extended,
   input  logic [8:0]           req_mouse_flags,
   input  logic signed [16:0]   req_delta_x,
   input  logic signed [16:0]   req_delta_y,
   input  logic                 req_driver_info_valid,
   input  logic [4:0]           req_driver_key_state,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [3:0]           rsp_message_kind,
   output logic [7:0]           rsp_word_param,
   output logic [31:0]          rsp_long_param,
   output logic [15:0]          rsp_pos_x,
   output logic [15:0]          rsp_pos_y,
   output logic                 rsp_last
);
   import iest_pkg::*;

   // Configuration registers.
   logic        input_enabled_ff;
   logic        buttons_swapped_ff;
   logic [15:0] screen_width_ff;
   logic [15:0] screen_height_ff;

   screen_cfg_type  screen;
   logic            q_full;
   logic            q_push;
   queue_entry_type q_entry;
   logic            q_pop;
   queue_entry_type q_head;
   logic            q_not_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         input_enabled_ff   <= 1'b1;
         buttons_swapped_ff <= 1'b0;
         screen_width_ff    <= 16'd1024;
         screen_height_ff   <= 16'd768;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_INPUT_ENABLED:   input_enabled_ff   <= csr_write_data[0];
            CSR_BUTTONS_SWAPPED: buttons_swapped_ff <= csr_write_data[0];
            CSR_SCREEN_WIDTH:    screen_width_ff    <= csr_write_data;
            CSR_SCREEN_HEIGHT:   screen_height_ff   <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // A zero screen size behaves as a single pixel.
   assign screen.width  = (screen_width_ff == '0) ? 16'd1 : screen_width_ff;
   assign screen.height = (screen_height_ff == '0) ? 16'd1 : screen_height_ff;

   // The front end classifies each request and scales absolute positions.
   iest_front u_front (
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_operation         (req_operation),
      .req_virtual_key       (req_virtual_key),
      .req_scan_code         (req_scan_code),
      .req_key_up            (req_key_up),
      .req_extended_key      (req_extended_key),
      .req_force_extended    (req_force_extended),
      .req_mouse_flags       (req_mouse_flags),
      .req_delta_x           (req_delta_x),
      .req_delta_y           (req_delta_y),
      .req_driver_info_valid (req_driver_info_valid),
      .req_driver_key_state  (req_driver_key_state),
      .input_enabled         (input_enabled_ff),
      .buttons_swapped       (buttons_swapped_ff),
      .screen                (screen),
      .q_full                (q_full),
      .q_push                (q_push),
      .q_entry               (q_entry)
   );

   // The queue lets the front end keep accepting while messages drain.
   iest_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head       (q_head),
      .not_empty  (q_not_empty),
      .full       (q_full)
   );

   // The back end applies requests strictly in order and emits messages.
   iest_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (q_head),
      .head_valid       (q_not_empty),
      .q_pop            (q_pop),
      .screen           (screen),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_message_kind (rsp_message_kind),
      .rsp_word_param   (rsp_word_param),
      .rsp_long_param   (rsp_long_param),
      .rsp_pos_x        (rsp_pos_x),
      .rsp_pos_y        (rsp_pos_y),
      .rsp_last         (rsp_last)
   );

endmodule

`default_nettype wire

>>> sv/iest_front.sv
// ----------------------------------------------------------------------------
// Input event tracker front end
// Accepts requests, drops them while input is disabled, scales absolute
// positions and decodes the mouse flags into an ordered message mask.
// ----------------------------------------------------------------------------
`default_nettype none

module iest_front (
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_operation,
   input  logic [7:0]               req_virtual_key,
   input  logic [7:0]               req_scan_code,
   input  logic                     req_key_up,
   input  logic                     req_extended_key,
   input  logic                     req_force_extended,
   input  logic [8:0]               req_mouse_flags,
   input  logic signed [16:0]       req_delta_x,
   input  logic signed [16:0]       req_delta_y,
   input  logic                     req_driver_info_valid,
   input  logic [4:0]               req_driver_key_state,
   input  logic                     input_enabled,
   input  logic                     buttons_swapped,
   input  iest_pkg::screen_cfg_type screen,
   input  logic                     q_full,
   output logic                     q_push,
   output iest_pkg::queue_entry_type q_entry
);
   import iest_pkg::*;

   logic [31:0]          prod_x;
   logic [31:0]          prod_y;
   logic                 left_down;
   logic                 left_up;
   logic                 right_down;
   logic                 right_up;
   logic [EV_MASK_W-1:0] mask;

   assign req_stall = q_full;
   assign q_push    = req_valid && !req_stall && input_enabled;

   // Absolute coordinates are 16-bit fractions of the screen.
   assign prod_x = {16'b0, req_delta_x[15:0]} * {16'b0, screen.width};
   assign prod_y = {16'b0, req_delta_y[15:0]} * {16'b0, screen.height};

   // The swap exchanges the physical left and right flags.
   assign left_down  = buttons_swapped ? req_mouse_flags[MF_RIGHT_DOWN]
                                       : req_mouse_flags[MF_LEFT_DOWN];
   assign left_up    = buttons_swapped ? req_mouse_flags[MF_RIGHT_UP]
                                       : req_mouse_flags[MF_LEFT_UP];
   assign right_down = buttons_swapped ? req_mouse_flags[MF_LEFT_DOWN]
                                       : req_mouse_flags[MF_RIGHT_DOWN];
   assign right_up   = buttons_swapped ? req_mouse_flags[MF_LEFT_UP]
                                       : req_mouse_flags[MF_RIGHT_UP];

   always_comb begin
      mask                 = '0;
      mask[EV_MOVE]        = req_mouse_flags[MF_MOVE];
      mask[EV_LEFT_DOWN]   = left_down;
      mask[EV_LEFT_UP]     = left_up;
      mask[EV_RIGHT_DOWN]  = right_down;
      mask[EV_RIGHT_UP]    = right_up;
      mask[EV_MIDDLE_DOWN] = req_mouse_flags[MF_MIDDLE_DOWN];
      mask[EV_MIDDLE_UP]   = req_mouse_flags[MF_MIDDLE_UP];
      mask[EV_WHEEL]       = req_mouse_flags[MF_WHEEL];
   end

   always_comb begin
      q_entry                   = '0;
      q_entry.is_mouse          = req_operation;
      q_entry.virtual_key       = req_virtual_key;
      q_entry.scan_code         = req_scan_code;
      q_entry.key_up            = req_key_up;
      q_entry.extended_key      = req_extended_key;
      q_entry.force_extended    = req_force_extended;
      q_entry.move              = req_mouse_flags[MF_MOVE];
      q_entry.absolute          = req_mouse_flags[MF_ABSOLUTE];
      q_entry.move_x            = req_mouse_flags[MF_ABSOLUTE] ? {1'b0, prod_x[31:16]}
                                                                 : req_delta_x;
      q_entry.move_y            = req_mouse_flags[MF_ABSOLUTE] ? {1'b0, prod_y[31:16]}
                                                                 : req_delta_y;
      q_entry.event_mask        = mask;
      q_entry.driver_info_valid = req_driver_info_valid;
      q_entry.driver_key_state  = req_driver_key_state;
   end

endmodule

`default_nettype wire

>>> sv/iest_queue.sv
// ----------------------------------------------------------------------------
// Input event tracker request queue
// A short first-in first-out queue of classified requests between the front
// end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module iest_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  iest_pkg::queue_entry_type push_entry,
   input  logic                      pop,
   output iest_pkg::queue_entry_type head,
   output logic                      not_empty,
   output logic                      full
);
   import iest_pkg::*;

   queue_entry_type        slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff;
   logic [QUEUE_CNT_W-1:0] count_in;

   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `ASSERT_NEVER(a_queue_no_overflow, clock, reset, push && full)
   `ASSERT_NEVER(a_queue_no_underflow, clock, reset, pop && !not_empty)
   `ASSERT_PROP(a_queue_count_bound, clock, reset, count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))

endmodule

`default_nettype wire

>>> sv/iest_back.sv
// ----------------------------------------------------------------------------
// Input event tracker back end
// Owns the key table, button and cursor state, applies each request in order
// and emits its messages through a registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module iest_back (
   input  logic                      clock,
   input  logic                      reset,
   input  iest_pkg::queue_entry_type head,
   input  logic                      head_valid,
   output logic                      q_pop,
   input  iest_pkg::screen_cfg_type  screen,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [3:0]                rsp_message_kind,
   output logic [7:0]                rsp_word_param,
   output logic [31:0]               rsp_long_param,
   output logic [15:0]               rsp_pos_x,
   output logic [15:0]               rsp_pos_y,
   output logic                      rsp_last
);
   import iest_pkg::*;

   function automatic logic [15:0] clip_rel(input logic [15:0] pos,
                                            input logic [16:0] delta,
                                            input logic [15:0] size);
      logic signed [17:0] sum;
      logic [15:0]        res;
      sum = $signed({2'b00, pos}) + $signed({delta[16], delta});
      if (sum < 18'sd0) begin
         res = '0;
      end else if (sum >= $signed({2'b00, size})) begin
         res = size - 16'd1;
      end else begin
         res = sum[15:0];
      end
      return res;
   endfunction

   back_state_type       state_ff;
   back_state_type       state_in;
   queue_entry_type      item_ff;
   queue_entry_type      item_in;

   // Key table: a memory plus one valid bit per entry; invalid reads as up.
   logic [1:0]                 key_mem [KEY_TABLE_DEPTH];
   logic [1:0]                 rd_data_ff;
   logic [KEY_IDX_W-1:0]       rd_addr;
   logic [KEY_TABLE_DEPTH-1:0] key_vld_ff;
   logic                       mem_we;
   logic [KEY_IDX_W-1:0]       mem_addr;

   logic [1:0]  shift_ff, shift_in;
   logic [1:0]  ctrl_ff, ctrl_in;
   logic [1:0]  alt_ff, alt_in;
   logic        left_ff, left_in;
   logic        middle_ff, middle_in;
   logic        right_ff, right_in;
   logic [15:0] cursor_x_ff, cursor_x_in;
   logic [15:0] cursor_y_ff, cursor_y_in;
   logic [EV_MASK_W-1:0] mask_ff, mask_in;
   logic [DK_W-1:0]      ks_ff, ks_in;

   logic         rsp_valid_ff, rsp_valid_in;
   msg_kind_type rsp_kind_ff, rsp_kind_in;
   logic [7:0]   rsp_word_ff, rsp_word_in;
   logic [31:0]  rsp_long_ff, rsp_long_in;
   logic         rsp_last_ff, rsp_last_in;
   logic         out_free;
   logic         out_load;

   // Key path signals.
   logic [KEY_IDX_W-1:0] vk;
   logic [1:0]   key_old;
   logic [1:0]   key_new;
   logic         alt_after;
   logic         ctrl_after;
   logic         sys_key;
   msg_kind_type key_kind;
   logic         key_prev;
   logic         key_context;
   logic [31:0]  key_long;

   // Mouse path signals.
   logic [DK_W-1:0] mod_word;
   logic            drv_apply;
   logic [DK_W-1:0] mouse_ks;
   logic            left_drv, middle_drv, right_drv;
   logic [15:0]     next_x, next_y;
   logic [EV_IDX_W-1:0]  emit_idx;
   logic [EV_MASK_W-1:0] emit_bit;
   logic [EV_MASK_W-1:0] mask_rest;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Keyboard request: old state, new state and the message fields.
   always_comb begin
      vk = item_ff.virtual_key;
      if (vk == KEY_SHIFT) begin
         key_old = shift_ff;
      end else if (vk == KEY_CONTROL) begin
         key_old = ctrl_ff;
      end else if (vk == KEY_ALT) begin
         key_old = alt_ff;
      end else begin
         key_old = key_vld_ff[vk] ? rd_data_ff : 2'b00;
      end

      if (item_ff.key_up) begin
         key_new  = {1'b0, key_old[KS_TOGGLE]};
         key_prev = 1'b1;
      end else begin
         key_new  = {1'b1, key_old[KS_DOWN] ? key_old[KS_TOGGLE] : ~key_old[KS_TOGGLE]};
         key_prev = key_old[KS_DOWN];
      end

      alt_after  = (vk == KEY_ALT) ? key_new[KS_DOWN] : alt_ff[KS_DOWN];
      ctrl_after = (vk == KEY_CONTROL) ? key_new[KS_DOWN] : ctrl_ff[KS_DOWN];

      // A release is judged on the state before it, a press on the state after.
      if (item_ff.key_up) begin
         sys_key  = alt_ff[KS_DOWN] && !ctrl_ff[KS_DOWN] && !item_ff.force_extended;
         key_kind = sys_key ? MSG_SYSKEYUP : MSG_KEYUP;
      end else begin
         sys_key  = alt_after && !ctrl_after;
         key_kind = sys_key ? MSG_SYSKEYDOWN : MSG_KEYDOWN;
      end
      key_context = sys_key && alt_after;

      key_long = {item_ff.key_up, key_prev, key_context, 4'b0000,
                  item_ff.extended_key, item_ff.scan_code, 16'd1};
   end

   // Mouse request: cursor move, driver modifiers and final button state.
   always_comb begin
      mod_word             = '0;
      mod_word[DK_LEFT]    = left_ff;
      mod_word[DK_RIGHT]   = right_ff;
      mod_word[DK_SHIFT]   = shift_ff[KS_DOWN];
      mod_word[DK_CONTROL] = ctrl_ff[KS_DOWN];
      mod_word[DK_MIDDLE]  = middle_ff;

      drv_apply = head.driver_info_valid && (head.driver_key_state != mod_word);
      mouse_ks  = head.driver_info_valid ? head.driver_key_state : mod_word;

      left_drv   = drv_apply ? head.driver_key_state[DK_LEFT]   : left_ff;
      right_drv  = drv_apply ? head.driver_key_state[DK_RIGHT]  : right_ff;
      middle_drv = drv_apply ? head.driver_key_state[DK_MIDDLE] : middle_ff;

      if (!head.move) begin
         next_x = cursor_x_ff;
         next_y = cursor_y_ff;
      end else if (head.absolute) begin
         next_x = head.move_x[15:0];
         next_y = head.move_y[15:0];
      end else begin
         next_x = clip_rel(cursor_x_ff, head.move_x, screen.width);
         next_y = clip_rel(cursor_y_ff, head.move_y, screen.height);
      end
   end

   // Lowest pending message goes out first.
   always_comb begin
      emit_idx = '0;
      for (int i = EV_MASK_W - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            emit_idx = EV_IDX_W'(i);
         end
      end
      emit_bit  = EV_MASK_W'(1) << emit_idx;
      mask_rest = mask_ff & ~emit_bit;
   end

   assign rd_addr  = (state_ff == BK_IDLE) ? head.virtual_key : item_ff.virtual_key;
   assign mem_addr = item_ff.virtual_key;

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      shift_in     = shift_ff;
      ctrl_in      = ctrl_ff;
      alt_in       = alt_ff;
      left_in      = left_ff;
      middle_in    = middle_ff;
      right_in     = right_ff;
      cursor_x_in  = cursor_x_ff;
      cursor_y_in  = cursor_y_ff;
      mask_in      = mask_ff;
      ks_in        = ks_ff;
      out_load     = 1'b0;
      rsp_kind_in  = rsp_kind_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_long_in  = rsp_long_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         BK_IDLE: begin
            if (head_valid) begin
               q_pop   = 1'b1;
               item_in = head;
               if (!head.is_mouse) begin
                  state_in = BK_KEY;
               end else begin
                  cursor_x_in = next_x;
                  cursor_y_in = next_y;
                  if (drv_apply) begin
                     shift_in = {head.driver_key_state[DK_SHIFT], 1'b0};
                     ctrl_in  = {head.driver_key_state[DK_CONTROL], 1'b0};
                  end
                  // A release after a press in the same request leaves it up.
                  left_in   = head.event_mask[EV_LEFT_UP] ? 1'b0 :
                              head.event_mask[EV_LEFT_DOWN] ? 1'b1 : left_drv;
                  right_in  = head.event_mask[EV_RIGHT_UP] ? 1'b0 :
                              head.event_mask[EV_RIGHT_DOWN] ? 1'b1 : right_drv;
                  middle_in = head.event_mask[EV_MIDDLE_UP] ? 1'b0 :
                              head.event_mask[EV_MIDDLE_DOWN] ? 1'b1 : middle_drv;
                  mask_in   = head.event_mask;
                  ks_in     = mouse_ks;
                  state_in  = (head.event_mask != '0) ? BK_EMIT : BK_IDLE;
               end
            end
         end
         BK_KEY: begin
            if (out_free) begin
               out_load    = 1'b1;
               rsp_kind_in = key_kind;
               rsp_word_in = item_ff.virtual_key;
               rsp_long_in = key_long;
               rsp_last_in = 1'b1;
               if (vk == KEY_SHIFT) begin
                  shift_in = key_new;
               end else if (vk == KEY_CONTROL) begin
                  ctrl_in = key_new;
               end else if (vk == KEY_ALT) begin
                  alt_in = key_new;
               end else begin
                  mem_we = 1'b1;
               end
               state_in = BK_IDLE;
            end
         end
         BK_EMIT: begin
            if (out_free) begin
               out_load    = 1'b1;
               rsp_kind_in = msg_kind_type'(4'(MSG_MOVE) + {1'b0, emit_idx});
               rsp_word_in = {3'b000, ks_ff};
               rsp_long_in = '0;
               rsp_last_in = (mask_rest == '0);
               mask_in     = mask_rest;
               if (mask_rest == '0) begin
                  state_in = BK_IDLE;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase

      if (out_free) begin
         rsp_valid_in = out_load;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_mem[mem_addr] <= key_new;
      end
      rd_data_ff <= key_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_vld_ff <= '0;
      end else if (mem_we) begin
         key_vld_ff[mem_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         shift_ff     <= 2'b00;
         ctrl_ff      <= 2'b00;
         alt_ff       <= 2'b00;
         left_ff      <= 1'b0;
         middle_ff    <= 1'b0;
         right_ff     <= 1'b0;
         cursor_x_ff  <= '0;
         cursor_y_ff  <= '0;
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         shift_ff     <= shift_in;
         ctrl_ff      <= ctrl_in;
         alt_ff       <= alt_in;
         left_ff      <= left_in;
         middle_ff    <= middle_in;
         right_ff     <= right_in;
         cursor_x_ff  <= cursor_x_in;
         cursor_y_ff  <= cursor_y_in;
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers; cursor fields follow the cursor at load time.
   logic [15:0] rsp_pos_x_ff;
   logic [15:0] rsp_pos_y_ff;

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      ks_ff       <= ks_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_word_ff <= rsp_word_in;
      rsp_long_ff <= rsp_long_in;
      rsp_last_ff <= rsp_last_in;
      if (out_load) begin
         rsp_pos_x_ff <= cursor_x_ff;
         rsp_pos_y_ff <= cursor_y_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_message_kind = rsp_kind_ff;
   assign rsp_word_param   = rsp_word_ff;
   assign rsp_long_param   = rsp_long_ff;
   assign rsp_pos_x        = rsp_pos_x_ff;
   assign rsp_pos_y        = rsp_pos_y_ff;
   assign rsp_last         = rsp_last_ff;

   `ASSERT_PROP(a_emit_has_work, clock, reset, (state_ff == BK_EMIT) |-> (mask_ff != '0))
   `ASSERT_NEVER(a_mem_no_shadow_key, clock, reset, mem_we && (mem_addr == KEY_SHIFT || mem_addr == KEY_CONTROL || mem_addr == KEY_ALT))
   `ASSERT_PROP(a_key_msg_last, clock, reset, (out_load && state_ff == BK_KEY) |=> (rsp_valid_ff && rsp_last_ff))

endmodule

`default_nettype wire

>>> tb/input_event_message_checker.sv
// ----------------------------------------------------------------------------
// Input event message checker
// Watches the request, message and register ports of the input event state
// tracker, keeps its own copy of the key table, buttons, cursor and screen
// setup, predicts every window message and compares each delivered message
// with the oldest prediction.
// ----------------------------------------------------------------------------
module input_event_message_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [1:0]           csr_index,
   input  logic [15:0]          csr_write_data,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic                 req_operation,
   input  logic [7:0]           req_virtual_key,
   input  logic [7:0]           req_scan_code,
   input  logic                 req_key_up,
   input  logic                 req_extended_key,
   input  logic                 req_force_extended,
   input  logic [8:0]           req_mouse_flags,
   input  logic signed [16:0]   req_delta_x,
   input  logic signed [16:0]   req_delta_y,
   input  logic                 req_driver_info_valid,
   input  logic [4:0]           req_driver_key_state,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [3:0]           rsp_message_kind,
   input  logic [7:0]           rsp_word_param,
   input  logic [31:0]          rsp_long_param,
   input  logic [15:0]          rsp_pos_x,
   input  logic [15:0]          rsp_pos_y,
   input  logic                 rsp_last,
   output int                   mismatch_count,
   output int                   pending_count,
   output int                   request_count,
   output int                   message_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import iest_pkg::*;

   // Bit positions of the logical button register.
   localparam int BTN_LEFT   = 0;
   localparam int BTN_MIDDLE = 1;
   localparam int BTN_RIGHT  = 2;

   localparam int PRINT_LIMIT = 100;

   typedef struct {
      msg_kind_type kind;
      logic [7:0]   word;
      logic [31:0]  lparam;
      logic [15:0]  x;
      logic [15:0]  y;
      logic         last;
   } window_msg_type;

   window_msg_type predicted_messages[$];

   logic [1:0]  key_table [KEY_TABLE_DEPTH];
   logic [2:0]  buttons;
   logic [15:0] cursor_x;
   logic [15:0] cursor_y;

   logic        enabled;
   logic        swapped;
   logic [15:0] width_reg;
   logic [15:0] height_reg;

   int errors;
   int requests;
   int checked;

   function automatic logic [4:0] modifier_bits();
      logic [4:0] bits;
      bits             = '0;
      bits[DK_LEFT]    = buttons[BTN_LEFT];
      bits[DK_RIGHT]   = buttons[BTN_RIGHT];
      bits[DK_SHIFT]   = key_table[KEY_SHIFT][KS_DOWN];
      bits[DK_CONTROL] = key_table[KEY_CONTROL][KS_DOWN];
      bits[DK_MIDDLE]  = buttons[BTN_MIDDLE];
      return bits;
   endfunction

   function automatic logic alt_without_control();
      return key_table[KEY_ALT][KS_DOWN] && !key_table[KEY_CONTROL][KS_DOWN];
   endfunction

   function automatic logic [15:0] clip_move(logic [15:0] pos, logic signed [16:0] delta,
                                             logic [15:0] size);
      int p;
      p = int'(pos) + int'(delta);
      if (p < 0) return 16'd0;
      if (p >= int'(size)) return size - 16'd1;
      return 16'(p);
   endfunction

   function automatic logic [15:0] scale_abs(logic [16:0] value, logic [15:0] size);
      logic [31:0] product;
      product = 32'(value[15:0]) * 32'(size);
      return product[31:16];
   endfunction

   task automatic queue_message(msg_kind_type kind, logic [7:0] word, logic [31:0] lparam);
      window_msg_type m;
      m.kind   = kind;
      m.word   = word;
      m.lparam = lparam;
      m.x      = cursor_x;
      m.y      = cursor_y;
      m.last   = 1'b0;
      predicted_messages.push_back(m);
   endtask

   // Updates the tracked state for one request and queues its messages.
   task automatic translate_event(
      input logic               is_mouse,
      input logic [7:0]         vk,
      input logic [7:0]         scan,
      input logic               up,
      input logic               ext,
      input logic               force_ext,
      input logic [8:0]         flags,
      input logic signed [16:0] dx,
      input logic signed [16:0] dy,
      input logic               dvalid,
      input logic [4:0]         dkeys
   );
      logic [31:0]    lparam;
      logic [1:0]     entry;
      logic [4:0]     mods;
      logic [15:0]    w;
      logic [15:0]    h;
      msg_kind_type   kind;
      int             queued_before;
      int             l_down, l_up, r_down, r_up;
      window_msg_type tail;

      if (!enabled) return;
      queued_before = predicted_messages.size();

      if (!is_mouse) begin
         lparam = 32'd1 | (32'(scan) << 16) | (32'(ext) << 24);
         if (up) begin
            // The system key test looks at the modifiers before the release.
            kind = (alt_without_control() && !force_ext) ? MSG_SYSKEYUP : MSG_KEYUP;
            key_table[vk][KS_DOWN] = 1'b0;
            lparam[30] = 1'b1;
            lparam[31] = 1'b1;
         end else begin
            entry = key_table[vk];
            if (entry[KS_DOWN]) lparam[30] = 1'b1;
            else entry[KS_TOGGLE] = ~entry[KS_TOGGLE];
            entry[KS_DOWN] = 1'b1;
            key_table[vk] = entry;
            kind = alt_without_control() ? MSG_SYSKEYDOWN : MSG_KEYDOWN;
         end
         if ((kind == MSG_SYSKEYDOWN || kind == MSG_SYSKEYUP) && key_table[KEY_ALT][KS_DOWN])
            lparam[29] = 1'b1;
         queue_message(kind, vk, lparam);
      end else begin
         w = (width_reg == 16'd0) ? 16'd1 : width_reg;
         h = (height_reg == 16'd0) ? 16'd1 : height_reg;
         if (flags[MF_MOVE]) begin
            if (flags[MF_ABSOLUTE]) begin
               cursor_x = scale_abs(dx, w);
               cursor_y = scale_abs(dy, h);
            end else begin
               cursor_x = clip_move(cursor_x, dx, w);
               cursor_y = clip_move(cursor_y, dy, h);
            end
         end

         if (dvalid) begin
            mods = dkeys;
            if (mods != modifier_bits()) begin
               buttons[BTN_LEFT]   = mods[DK_LEFT];
               buttons[BTN_RIGHT]  = mods[DK_RIGHT];
               buttons[BTN_MIDDLE] = mods[DK_MIDDLE];
               key_table[KEY_SHIFT]            = 2'b00;
               key_table[KEY_SHIFT][KS_DOWN]   = mods[DK_SHIFT];
               key_table[KEY_CONTROL]          = 2'b00;
               key_table[KEY_CONTROL][KS_DOWN] = mods[DK_CONTROL];
            end
         end else begin
            mods = modifier_bits();
         end

         // Swapping only changes which raw flags mean the logical left and right buttons.
         l_down = swapped ? MF_RIGHT_DOWN : MF_LEFT_DOWN;
         l_up   = swapped ? MF_RIGHT_UP   : MF_LEFT_UP;
         r_down = swapped ? MF_LEFT_DOWN  : MF_RIGHT_DOWN;
         r_up   = swapped ? MF_LEFT_UP    : MF_RIGHT_UP;

         if (flags[MF_MOVE]) queue_message(MSG_MOVE, 8'(mods), 32'd0);
         if (flags[l_down]) begin
            buttons[BTN_LEFT] = 1'b1;
            queue_message(MSG_LBUTTONDOWN, 8'(mods), 32'd0);
         end
         if (flags[l_up]) begin
            buttons[BTN_LEFT] = 1'b0;
            queue_message(MSG_LBUTTONUP, 8'(mods), 32'd0);
         end
         if (flags[r_down]) begin
            buttons[BTN_RIGHT] = 1'b1;
            queue_message(MSG_RBUTTONDOWN, 8'(mods), 32'd0);
         end
         if (flags[r_up]) begin
            buttons[BTN_RIGHT] = 1'b0;
            queue_message(MSG_RBUTTONUP, 8'(mods), 32'd0);
         end
         if (flags[MF_MIDDLE_DOWN]) begin
            buttons[BTN_MIDDLE] = 1'b1;
            queue_message(MSG_MBUTTONDOWN, 8'(mods), 32'd0);
         end
         if (flags[MF_MIDDLE_UP]) begin
            buttons[BTN_MIDDLE] = 1'b0;
            queue_message(MSG_MBUTTONUP, 8'(mods), 32'd0);
         end
         if (flags[MF_WHEEL]) queue_message(MSG_WHEEL, 8'(mods), 32'd0);
      end

      if (predicted_messages.size() > queued_before) begin
         tail      = predicted_messages.pop_back();
         tail.last = 1'b1;
         predicted_messages.push_back(tail);
      end
   endtask

   task automatic report_mismatch(string text);
      if (errors < PRINT_LIMIT) $display("[%0t] MISMATCH: %s", $realtime, text);
      errors++;
   endtask

   task automatic check_message();
      window_msg_type want;
      if (predicted_messages.size() == 0) begin
         report_mismatch($sformatf("message kind %0d arrived with nothing predicted",
                                   rsp_message_kind));
         return;
      end
      want = predicted_messages.pop_front();
      checked++;
      if (rsp_message_kind !== want.kind)
         report_mismatch($sformatf("kind got %0d want %0d", rsp_message_kind, want.kind));
      if (rsp_word_param !== want.word)
         report_mismatch($sformatf("word_param got %h want %h", rsp_word_param, want.word));
      if (rsp_long_param !== want.lparam)
         report_mismatch($sformatf("long_param got %h want %h", rsp_long_param, want.lparam));
      if (rsp_pos_x !== want.x)
         report_mismatch($sformatf("pos_x got %0d want %0d", rsp_pos_x, want.x));
      if (rsp_pos_y !== want.y)
         report_mismatch($sformatf("pos_y got %0d want %0d", rsp_pos_y, want.y));
      if (rsp_last !== want.last)
         report_mismatch($sformatf("last got %b want %b", rsp_last, want.last));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         predicted_messages.delete();
         foreach (key_table[i]) key_table[i] = 2'b00;
         buttons    = 3'b000;
         cursor_x   = 16'd0;
         cursor_y   = 16'd0;
         enabled    = 1'b1;
         swapped    = 1'b0;
         width_reg  = 16'd1024;
         height_reg = 16'd768;
         errors     = 0;
         requests   = 0;
         checked    = 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_INPUT_ENABLED:   enabled    = csr_write_data[0];
               CSR_BUTTONS_SWAPPED: swapped    = csr_write_data[0];
               CSR_SCREEN_WIDTH:    width_reg  = csr_write_data;
               CSR_SCREEN_HEIGHT:   height_reg = csr_write_data;
               default: ;
            endcase
         end
         // Messages are checked before new requests are predicted, so the oldest
         // prediction always belongs to an earlier request.
         if (rsp_valid && !rsp_stall) check_message();
         if (req_valid && !req_stall) begin
            requests++;
            translate_event(req_operation, req_virtual_key, req_scan_code, req_key_up,
                            req_extended_key, req_force_extended, req_mouse_flags,
                            req_delta_x, req_delta_y, req_driver_info_valid,
                            req_driver_key_state);
         end
      end
      mismatch_count <= errors;
      pending_count  <= predicted_messages.size();
      request_count  <= requests;
      message_count  <= checked;
   end

endmodule

>>> tb/tb_input_event_state_tracker_core.sv
// ----------------------------------------------------------------------------
// Input event state tracker testbench
// Drives keyboard and mouse requests through the tracker under several screen,
// swap and enable settings, with random gaps and stalls on both channels, and
// leaves prediction and comparison of every window message to the checker.
// ----------------------------------------------------------------------------
module tb_input_event_state_tracker_core;
   timeunit 1ns;
   timeprecision 1ps;

   import iest_pkg::*;

   localparam int CYCLE_LIMIT   = 300000;
   // Cycles allowed after the last predicted message for requests that give
   // no message but may still be inside the queue or the back end.
   localparam int SETTLE_CYCLES = 40;
   // Length of the long receiver hold-off that fills the request queue.
   localparam int HOLD_CYCLES   = 120;

   localparam logic OP_KEY   = 1'b0;
   localparam logic OP_MOUSE = 1'b1;

   localparam logic [8:0] FL_NONE        = 9'd0;
   localparam logic [8:0] FL_MOVE        = 9'b1 << MF_MOVE;
   localparam logic [8:0] FL_ABSOLUTE    = 9'b1 << MF_ABSOLUTE;
   localparam logic [8:0] FL_LEFT_DOWN   = 9'b1 << MF_LEFT_DOWN;
   localparam logic [8:0] FL_LEFT_UP     = 9'b1 << MF_LEFT_UP;
   localparam logic [8:0] FL_RIGHT_UP    = 9'b1 << MF_RIGHT_UP;
   localparam logic [8:0] FL_MIDDLE_UP   = 9'b1 << MF_MIDDLE_UP;
   localparam logic [8:0] FL_WHEEL       = 9'b1 << MF_WHEEL;
   localparam logic [8:0] FL_ALL         = 9'h1FF;

   // Extremes of the signed 17-bit motion fields.
   localparam logic [16:0] DELTA_MIN = 17'h10000;
   localparam logic [16:0] DELTA_MAX = 17'h0FFFF;

   typedef struct {
      logic        op;
      logic [7:0]  vk;
      logic [7:0]  scan;
      logic        up;
      logic        ext;
      logic        force_ext;
      logic [8:0]  flags;
      logic [16:0] dx;
      logic [16:0] dy;
      logic        dvalid;
      logic [4:0]  dkeys;
   } raw_event_type;

   // Every input of the block starts at a known value.
   logic                 clock                 = 1'b0;
   logic                 reset                 = 1'b1;
   logic                 csr_write_enable      = 1'b0;
   logic [1:0]           csr_index             = '0;
   logic [15:0]          csr_write_data        = '0;
   logic                 req_valid             = 1'b0;
   logic                 req_stall;
   logic                 req_operation         = 1'b0;
   logic [7:0]           req_virtual_key       = '0;
   logic [7:0]           req_scan_code         = '0;
   logic                 req_key_up            = 1'b0;
   logic                 req_extended_key      = 1'b0;
   logic                 req_force_extended    = 1'b0;
   logic [8:0]           req_mouse_flags       = '0;
   logic signed [16:0]   req_delta_x           = '0;
   logic signed [16:0]   req_delta_y           = '0;
   logic                 req_driver_info_valid = 1'b0;
   logic [4:0]           req_driver_key_state  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall             = 1'b1;
   logic [3:0]           rsp_message_kind;
   logic [7:0]           rsp_word_param;
   logic [31:0]          rsp_long_param;
   logic [15:0]          rsp_pos_x;
   logic [15:0]          rsp_pos_y;
   logic                 rsp_last;

   int mismatch_count;
   int pending_count;
   int request_count;
   int message_count;
   int cycle_count;

   // Shared between the request and message processes: no_idle turns off the
   // random gaps on both sides, hold_off_go asks the receiver for one long stall.
   bit no_idle     = 1'b0;
   bit hold_off_go = 1'b0;

   always #10 clock = ~clock;

   input_event_state_tracker_core u_top (.*);

   input_event_message_checker u_checker (.*);

   function automatic raw_event_type make_key(logic [7:0] vk, logic [7:0] scan, logic up,
                                              logic ext, logic force_ext);
      raw_event_type ev;
      ev           = '{default: '0};
      ev.op        = OP_KEY;
      ev.vk        = vk;
      ev.scan      = scan;
      ev.up        = up;
      ev.ext       = ext;
      ev.force_ext = force_ext;
      return ev;
   endfunction

   function automatic raw_event_type make_mouse(logic [8:0] flags, logic [16:0] dx,
                                                logic [16:0] dy, logic dvalid,
                                                logic [4:0] dkeys);
      raw_event_type ev;
      ev        = '{default: '0};
      ev.op     = OP_MOUSE;
      ev.flags  = flags;
      ev.dx     = dx;
      ev.dy     = dy;
      ev.dvalid = dvalid;
      ev.dkeys  = dkeys;
      return ev;
   endfunction

   // Offers one request after a random gap and holds it until it is taken.
   // Valid stays high afterwards so back-to-back requests need no extra edge.
   task automatic send_request(raw_event_type ev);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_operation         <= ev.op;
      req_virtual_key       <= ev.vk;
      req_scan_code         <= ev.scan;
      req_key_up            <= ev.up;
      req_extended_key      <= ev.ext;
      req_force_extended    <= ev.force_ext;
      req_mouse_flags       <= ev.flags;
      req_delta_x           <= ev.dx;
      req_delta_y           <= ev.dy;
      req_driver_info_valid <= ev.dvalid;
      req_driver_key_state  <= ev.dkeys;
      req_valid             <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   // Stops offering requests and waits until every predicted message is in,
   // then lets the block finish any request that gives no message.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Registers are only written once the block has gone quiet.
   task automatic apply_setup(logic en, logic swap, logic [15:0] w, logic [15:0] h);
      drain();
      write_reg(CSR_INPUT_ENABLED, 16'(en));
      write_reg(CSR_BUTTONS_SWAPPED, 16'(swap));
      write_reg(CSR_SCREEN_WIDTH, w);
      write_reg(CSR_SCREEN_HEIGHT, h);
   endtask

   // Random requests. Key requests mostly hit Shift, Control, Alt and two
   // ordinary keys so presses and releases pair up and the system key and
   // repeat paths are exercised; mouse requests are mostly a move with an
   // occasional button or wheel flag, the rest fully random flags and motion.
   task automatic run_phase(int count);
      raw_event_type ev;
      int            pick;
      for (int n = 0; n < count; n++) begin
         ev.op        = 1'($urandom_range(0, 1));
         ev.vk        = 8'($urandom);
         ev.scan      = 8'($urandom);
         ev.up        = 1'($urandom);
         ev.ext       = 1'($urandom);
         ev.force_ext = ($urandom_range(0, 7) == 0);
         ev.flags     = 9'($urandom);
         ev.dx        = 17'($urandom);
         ev.dy        = 17'($urandom);
         ev.dvalid    = 1'($urandom);
         ev.dkeys     = 5'($urandom);
         if (ev.op == OP_KEY) begin
            pick = $urandom_range(0, 9);
            case (pick)
               0, 1: ev.vk = KEY_SHIFT;
               2, 3: ev.vk = KEY_CONTROL;
               4, 5: ev.vk = KEY_ALT;
               6:    ev.vk = 8'h41;
               7:    ev.vk = 8'h0D;
               default: ;
            endcase
         end else begin
            if ($urandom_range(0, 3) != 0) begin
               ev.flags = FL_MOVE;
               if ($urandom_range(0, 3) == 0) ev.flags |= FL_ABSOLUTE;
               for (int b = MF_LEFT_DOWN; b <= MF_WHEEL; b++)
                  if ($urandom_range(0, 5) == 0) ev.flags[b] = 1'b1;
               // Small relative steps keep the cursor wandering inside the screen.
               if (!ev.flags[MF_ABSOLUTE]) begin
                  ev.dx = 17'(int'($urandom_range(0, 400)) - 200);
                  ev.dy = 17'(int'($urandom_range(0, 400)) - 200);
               end
            end
            ev.dvalid = ($urandom_range(0, 3) == 0);
         end
         send_request(ev);
      end
   endtask

   // Message receiver: a random stall before every message, a long hold-off
   // on request, and no random stalls while no_idle is set.
   initial begin
      int gap;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_go) begin
            hold_off_go = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         gap = no_idle ? 0 : $urandom_range(0, 3);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall) && !hold_off_go);
      end
   end

   // Watchdog: a hung block or a lost message ends the run here.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed requests under the reset setup of a 1024 by 768 screen.
      // Plain press, auto-repeat with the previous bit set, and release.
      send_request(make_key(8'h41, 8'h1E, 1'b0, 1'b0, 1'b0));
      send_request(make_key(8'h41, 8'h1E, 1'b0, 1'b0, 1'b0));
      send_request(make_key(8'h41, 8'h1E, 1'b1, 1'b0, 1'b0));
      // Extreme key codes, scan codes and the extended flag.
      send_request(make_key(8'hFF, 8'hFF, 1'b0, 1'b1, 1'b0));
      send_request(make_key(8'h00, 8'h00, 1'b1, 1'b0, 1'b1));
      // Alt alone turns key messages into system key messages with context set.
      send_request(make_key(KEY_ALT, 8'h38, 1'b0, 1'b0, 1'b0));
      send_request(make_key(8'h73, 8'h3E, 1'b0, 1'b0, 1'b0));
      send_request(make_key(8'h73, 8'h3E, 1'b1, 1'b0, 1'b0));
      // Control together with Alt falls back to ordinary key messages.
      send_request(make_key(KEY_CONTROL, 8'h1D, 1'b0, 1'b0, 1'b0));
      send_request(make_key(8'h44, 8'h20, 1'b0, 1'b0, 1'b0));
      send_request(make_key(KEY_CONTROL, 8'h1D, 1'b1, 1'b0, 1'b0));
      // An Alt release coming from AltGr is never a system key release.
      send_request(make_key(KEY_ALT, 8'h38, 1'b1, 1'b1, 1'b1));
      // Absolute move at full scale; bit 16 of the motion must be ignored.
      send_request(make_mouse(FL_MOVE | FL_ABSOLUTE, DELTA_MAX, 17'h1FFFF, 1'b0, 5'd0));
      // Relative moves clipped at both screen edges.
      send_request(make_mouse(FL_MOVE, DELTA_MIN, DELTA_MIN, 1'b0, 5'd0));
      send_request(make_mouse(FL_MOVE, DELTA_MAX, DELTA_MAX, 1'b0, 5'd0));
      // Every flag at once gives the longest run of messages.
      send_request(make_mouse(FL_ALL, 17'd0, 17'd0, 1'b0, 5'd0));
      // No flags: driver bits still change buttons, Shift and Control silently.
      send_request(make_mouse(FL_NONE, 17'd5, 17'd5, 1'b1, 5'b11111));
      send_request(make_key(8'h41, 8'h1E, 1'b0, 1'b0, 1'b0));
      // Driver bits equal to the current modifiers leave the state alone.
      send_request(make_mouse(FL_MOVE, 17'd3, 17'h1FFFE, 1'b1, 5'b11111));
      // Driver bits that clear everything, then releases and the wheel.
      send_request(make_mouse(FL_WHEEL | FL_LEFT_UP | FL_RIGHT_UP | FL_MIDDLE_UP,
                              17'd0, 17'd0, 1'b1, 5'b00000));
      send_request(make_mouse(FL_LEFT_DOWN | FL_LEFT_UP, 17'd0, 17'd0, 1'b0, 5'd0));
      send_request(make_mouse(FL_MOVE, 17'd1, 17'd1, 1'b0, 5'd0));

      // Largest screen with swapped buttons.
      apply_setup(1'b1, 1'b1, 16'hFFFF, 16'hFFFF);
      run_phase(60);

      // One-pixel screen. Midway the receiver holds off while requests keep
      // coming back to back, so the queue fills and the input stalls.
      apply_setup(1'b1, 1'b0, 16'd1, 16'd1);
      run_phase(40);
      hold_off_go = 1'b1;
      no_idle     = 1'b1;
      run_phase(20);
      no_idle     = 1'b0;

      // A zero width acts as one pixel. The sender pauses in the middle
      // until every message has arrived.
      apply_setup(1'b1, 1'b1, 16'd0, 16'd300);
      run_phase(30);
      drain();
      run_phase(30);

      // Disabled input: requests are dropped and leave the state untouched.
      apply_setup(1'b0, 1'b0, 16'd800, 16'd600);
      run_phase(12);

      // Back on, starting with a stretch free of gaps and stalls.
      apply_setup(1'b1, 1'b0, 16'd640, 16'd480);
      no_idle = 1'b1;
      run_phase(30);
      no_idle = 1'b0;
      run_phase(30);

      apply_setup(1'b1, 1'b1, 16'd1920, 16'd1080);
      run_phase(60);

      apply_setup(1'b1, 1'b0, 16'd1024, 16'd768);
      run_phase(60);

      drain();

      $display("Covered %0d requests (keys, system keys, moves, buttons, wheel, driver",
               request_count);
      $display("modifiers) over eight register setups; %0d messages compared, %0d wrong.",
               message_count, mismatch_count);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+sv
sv/iest_pkg.sv
sv/iest_front.sv
sv/iest_queue.sv
sv/iest_back.sv
sv/input_event_state_tracker_core.sv
tb/input_event_message_checker.sv
tb/tb_input_event_state_tracker_core.sv
